// ----- hw/rtl/srt_pkg.sv -----
// ---------------------------------------------------------------------------
// srt_pkg
// shared types and codes of the slot reservation table
// ---------------------------------------------------------------------------
package srt_pkg;

  // request kinds
  localparam logic [2:0] KIND_APPEND    = 3'd0;
  localparam logic [2:0] KIND_BOOK      = 3'd1;
  localparam logic [2:0] KIND_CANCEL    = 3'd2;
  localparam logic [2:0] KIND_SORT      = 3'd3;
  localparam logic [2:0] KIND_LIST_ALL  = 3'd4;
  localparam logic [2:0] KIND_LIST_FREE = 3'd5;

  // result status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_OCCUPIED   = 3'd1;
  localparam logic [2:0] ST_VACANT     = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_LIST_ENTRY = 3'd5;
  localparam logic [2:0] ST_LIST_EMPTY = 3'd6;

  // one table entry as stored in memory
  typedef struct packed {
    logic        taken;
    logic [15:0] end_time;
    logic [15:0] start_time;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_SEND = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/srt_ram.sv -----
// ---------------------------------------------------------------------------
// srt_ram
// generic simple dual-port ram, one write port, registered read
// ---------------------------------------------------------------------------
module srt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/slot_reservation_table.sv -----
// ---------------------------------------------------------------------------
// slot_reservation_table
// table of interval slots with append, book, cancel, sort and listing
// ---------------------------------------------------------------------------
// usage:
//   one request item enters on the s_axis side (kind in tuser, times in tdata)
//   and answers with one or more result items on the m_axis side; the final
//   result of each request carries tlast
//   slots live in one ram (start, end, booked mark), read through a registered
//   port; the controller walks it one entry at a time, reading in S_RD, comparing in S_CMP
// work per request kind (n = stored slots):
//   append and unused kinds: answered in the finish state, without a walk
//   book / cancel: walk the entries up to the first match, then finish
//   listing: walk every entry, holding while the output stalls
//   sort: bubble passes over the ram, up to n passes
//   one request is handled at a time; s_axis_tready is high only when idle
// reset: clears the slot count and the controller; no ram clearing pass
// stall: a result waits in the output register; a listing holds its walk
//   until the register frees, other work never drops or repeats a result
// ---------------------------------------------------------------------------
module slot_reservation_table #(
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // start_time[15:0], end_time[31:16]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // slot_start[15:0], slot_end[31:16], slot_taken[32]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1) > AW + 1 ? $clog2(MAX_SLOTS + 1) : AW + 1;

  srt_pkg::state_t state;
  logic [CW-1:0]   count;       // stored slots
  logic [CW-1:0]   idx;         // walk position, also the ram read address
  logic [2:0]      op;
  logic [15:0]     key_start;
  logic [15:0]     key_end;
  srt_pkg::slot_t  cur;         // sort: entry carried along the pass
  logic            moved;       // sort: a swap happened in this pass
  srt_pkg::slot_t  pend;        // listing: entry held back to place tlast
  logic            have_pend;
  logic [2:0]      res_status;  // status of the closing result

  // output register
  logic            o_valid;
  logic [2:0]      o_status;
  srt_pkg::slot_t  o_slot;
  logic            o_last;

  // ram ports
  logic            we;
  logic [AW-1:0]   waddr;
  srt_pkg::slot_t  wdata;
  srt_pkg::slot_t  rd;
  logic [srt_pkg::SLOT_W-1:0] rd_raw;

  logic            accept;
  logic            can_emit;
  logic            emit;
  logic [2:0]      e_status;
  srt_pkg::slot_t  e_slot;
  logic            e_last;
  logic            is_end;      // current entry is the final stored one
  logic            match;
  logic            qual;
  logic            swap;
  logic            full;

  assign rd       = srt_pkg::slot_t'(rd_raw);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign can_emit = !o_valid || m_axis_tready;
  assign is_end   = (idx + CW'(1)) == count;
  assign match    = (rd.start_time == key_start) && (rd.end_time == key_end);
  assign qual     = (op == srt_pkg::KIND_LIST_ALL) || !rd.taken;
  assign swap     = cur.start_time > rd.start_time;
  assign full     = count == CW'(MAX_SLOTS);

  assign s_axis_tready = (state == srt_pkg::S_IDLE);

  srt_ram #(
    .W(srt_pkg::SLOT_W),
    .D(MAX_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx[AW-1:0]),
    .rdata(rd_raw)
  );

  // ram writes and result generation
  always_comb begin
    we       = 1'b0;
    waddr    = idx[AW-1:0];
    wdata    = cur;
    emit     = 1'b0;
    e_status = res_status;
    e_slot   = '0;
    e_last   = 1'b1;
    unique case (state)
      srt_pkg::S_IDLE: begin
        // append goes to the first unused entry
        if (accept && s_axis_tuser == srt_pkg::KIND_APPEND && !full) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = '{taken: 1'b0, end_time: s_axis_tdata[31:16],
                    start_time: s_axis_tdata[15:0]};
        end
      end
      srt_pkg::S_RD: begin
      end
      srt_pkg::S_CMP: begin
        if (op == srt_pkg::KIND_BOOK || op == srt_pkg::KIND_CANCEL) begin
          if (match && (rd.taken != (op == srt_pkg::KIND_BOOK))) begin
            we          = 1'b1;
            wdata       = rd;
            wdata.taken = (op == srt_pkg::KIND_BOOK);
          end
        end else if (op == srt_pkg::KIND_SORT) begin
          // the smaller of the carried entry and the new one settles at idx-1
          if (idx != '0) begin
            we    = 1'b1;
            waddr = AW'(idx - CW'(1));
            wdata = swap ? rd : cur;
          end
        end else begin
          // listing: a new qualifying entry releases the one held back
          if (qual && have_pend && can_emit) begin
            emit     = 1'b1;
            e_status = srt_pkg::ST_LIST_ENTRY;
            e_slot   = pend;
            e_last   = 1'b0;
          end
        end
      end
      srt_pkg::S_SEND: begin
        // carried entry closes the pass at the top position
        we    = 1'b1;
        wdata = cur;
      end
      srt_pkg::S_FIN: begin
        if (can_emit) begin
          emit = 1'b1;
          if (have_pend) begin
            e_status = srt_pkg::ST_LIST_ENTRY;
            e_slot   = pend;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srt_pkg::S_IDLE;
      count     <= '0;
      idx       <= '0;
      have_pend <= 1'b0;
      moved     <= 1'b0;
    end else begin
      unique case (state)
        srt_pkg::S_IDLE: begin
          if (accept) begin
            op        <= s_axis_tuser;
            key_start <= s_axis_tdata[15:0];
            key_end   <= s_axis_tdata[31:16];
            idx       <= '0;
            have_pend <= 1'b0;
            moved     <= 1'b0;
            unique case (s_axis_tuser)
              srt_pkg::KIND_APPEND: begin
                if (full) begin
                  res_status <= srt_pkg::ST_FULL;
                end else begin
                  res_status <= srt_pkg::ST_DONE;
                  count      <= count + CW'(1);
                end
                state <= srt_pkg::S_FIN;
              end
              srt_pkg::KIND_BOOK, srt_pkg::KIND_CANCEL: begin
                res_status <= srt_pkg::ST_NO_SLOT;
                state      <= (count == '0) ? srt_pkg::S_FIN : srt_pkg::S_RD;
              end
              srt_pkg::KIND_SORT: begin
                res_status <= srt_pkg::ST_DONE;
                state      <= (count < CW'(2)) ? srt_pkg::S_FIN : srt_pkg::S_RD;
              end
              srt_pkg::KIND_LIST_ALL, srt_pkg::KIND_LIST_FREE: begin
                res_status <= srt_pkg::ST_LIST_EMPTY;
                state      <= (count == '0) ? srt_pkg::S_FIN : srt_pkg::S_RD;
              end
              default: begin
                res_status <= srt_pkg::ST_NO_SLOT;
                state      <= srt_pkg::S_FIN;
              end
            endcase
          end
        end
        srt_pkg::S_RD: begin
          // read data for idx shows up next cycle
          state <= srt_pkg::S_CMP;
        end
        srt_pkg::S_CMP: begin
          if (op == srt_pkg::KIND_BOOK || op == srt_pkg::KIND_CANCEL) begin
            if (match) begin
              if (op == srt_pkg::KIND_BOOK) begin
                res_status <= rd.taken ? srt_pkg::ST_OCCUPIED : srt_pkg::ST_DONE;
              end else begin
                res_status <= rd.taken ? srt_pkg::ST_DONE : srt_pkg::ST_VACANT;
              end
              state <= srt_pkg::S_FIN;
            end else if (is_end) begin
              state <= srt_pkg::S_FIN;
            end else begin
              idx   <= idx + CW'(1);
              state <= srt_pkg::S_RD;
            end
          end else if (op == srt_pkg::KIND_SORT) begin
            if (idx == '0) begin
              cur   <= rd;
              idx   <= CW'(1);
              state <= srt_pkg::S_RD;
            end else begin
              if (swap) begin
                moved <= 1'b1;
              end else begin
                cur <= rd;
              end
              if (is_end) begin
                state <= srt_pkg::S_SEND;
              end else begin
                idx   <= idx + CW'(1);
                state <= srt_pkg::S_RD;
              end
            end
          end else begin
            // listing walk, holds while a held-back entry waits for the busy output register
            if (!(qual && have_pend && !can_emit)) begin
              if (qual) begin
                pend      <= rd;
                have_pend <= 1'b1;
              end
              if (is_end) begin
                state <= srt_pkg::S_FIN;
              end else begin
                idx   <= idx + CW'(1);
                state <= srt_pkg::S_RD;
              end
            end
          end
        end
        srt_pkg::S_SEND: begin
          if (moved) begin
            moved <= 1'b0;
            idx   <= '0;
            state <= srt_pkg::S_RD;
          end else begin
            state <= srt_pkg::S_FIN;
          end
        end
        srt_pkg::S_FIN: begin
          if (can_emit) begin
            have_pend <= 1'b0;
            state     <= srt_pkg::S_IDLE;
          end
        end
        default: begin
          state <= srt_pkg::S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= emit || (o_valid && !m_axis_tready);
    end
    if (emit) begin
      o_status <= e_status;
      o_slot   <= e_slot;
      o_last   <= e_last;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_status;
  assign m_axis_tdata  = {7'd0, o_slot.taken, o_slot.end_time, o_slot.start_time};
  assign m_axis_tlast  = o_last;

endmodule

// ----- test/tb_slot_reservation_table.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_slot_reservation_table
// drives append, book, cancel, sort, listing and unused-kind requests with random gaps on
// both sides and checks every result item against a behavioral slot table
// ---------------------------------------------------------------------------
module tb_slot_reservation_table;

  localparam int MAX_SLOTS = 64;
  localparam int WATCHDOG  = 200000;
  localparam int N_RANDOM  = 130;
  localparam logic [2:0] KIND_BAD6 = 3'd6;
  localparam logic [2:0] KIND_BAD7 = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] slot_start;
    logic [15:0] slot_end;
    logic        slot_taken;
    logic        last;
  } answer_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic        fixed;      // expected status typed in below
    logic [2:0]  fixed_st;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // start_time[15:0], end_time[31:16]
  logic [2:0]  s_axis_tuser = '0;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // slot_start[15:0], slot_end[31:16], slot_taken[32]
  logic [2:0]  m_axis_tuser;       // status[2:0]
  logic        m_axis_tlast;

  slot_reservation_table #(.MAX_SLOTS(MAX_SLOTS)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral copy of the table
  logic [15:0] tbl_start [MAX_SLOTS];
  logic [15:0] tbl_end   [MAX_SLOTS];
  logic        tbl_taken [MAX_SLOTS];
  int          tbl_count = 0;
  answer_t     pending_answers [$];
  int          fails = 0;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;

  function automatic answer_t plain(logic [2:0] st);
    answer_t a;
    a = '0;
    a.status = st;
    a.last = 1'b1;
    return a;
  endfunction

  // apply one request to the table, queue its answers
  task automatic predict_request(logic [2:0] kind, logic [15:0] st, logic [15:0] en);
    int idx;
    int n;
    bit moved;
    answer_t a;
    logic [15:0] ts, te;
    logic tt;
    idx = -1;
    n = 0;
    case (kind)
      srt_pkg::KIND_APPEND: begin
        if (tbl_count >= MAX_SLOTS) pending_answers.push_back(plain(srt_pkg::ST_FULL));
        else begin
          tbl_start[tbl_count] = st;
          tbl_end[tbl_count] = en;
          tbl_taken[tbl_count] = 1'b0;
          tbl_count++;
          pending_answers.push_back(plain(srt_pkg::ST_DONE));
        end
      end
      srt_pkg::KIND_BOOK, srt_pkg::KIND_CANCEL: begin
        for (int i = tbl_count - 1; i >= 0; i--)
          if (tbl_start[i] == st && tbl_end[i] == en) idx = i;
        if (idx < 0) pending_answers.push_back(plain(srt_pkg::ST_NO_SLOT));
        else if (kind == srt_pkg::KIND_BOOK) begin
          if (tbl_taken[idx]) pending_answers.push_back(plain(srt_pkg::ST_OCCUPIED));
          else begin
            tbl_taken[idx] = 1'b1;
            pending_answers.push_back(plain(srt_pkg::ST_DONE));
          end
        end else begin
          if (!tbl_taken[idx]) pending_answers.push_back(plain(srt_pkg::ST_VACANT));
          else begin
            tbl_taken[idx] = 1'b0;
            pending_answers.push_back(plain(srt_pkg::ST_DONE));
          end
        end
      end
      srt_pkg::KIND_SORT: begin
        // stable bubble sort on start time
        do begin
          moved = 1'b0;
          for (int i = 0; i + 1 < tbl_count; i++)
            if (tbl_start[i] > tbl_start[i+1]) begin
              ts = tbl_start[i]; te = tbl_end[i]; tt = tbl_taken[i];
              tbl_start[i] = tbl_start[i+1]; tbl_end[i] = tbl_end[i+1];
              tbl_taken[i] = tbl_taken[i+1];
              tbl_start[i+1] = ts; tbl_end[i+1] = te; tbl_taken[i+1] = tt;
              moved = 1'b1;
            end
        end while (moved);
        pending_answers.push_back(plain(srt_pkg::ST_DONE));
      end
      srt_pkg::KIND_LIST_ALL, srt_pkg::KIND_LIST_FREE: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (kind == srt_pkg::KIND_LIST_FREE && tbl_taken[i]) continue;
          a.status = srt_pkg::ST_LIST_ENTRY;
          a.slot_start = tbl_start[i];
          a.slot_end = tbl_end[i];
          a.slot_taken = tbl_taken[i];
          a.last = 1'b0;
          pending_answers.push_back(a);
          n++;
        end
        if (n == 0) pending_answers.push_back(plain(srt_pkg::ST_LIST_EMPTY));
        else pending_answers[$].last = 1'b1;
      end
      default: pending_answers.push_back(plain(srt_pkg::ST_NO_SLOT));
    endcase
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    else if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 60)) @(posedge clk);
  endtask

  // one request through the slave side; prediction made at acceptance
  task automatic send_request(logic [2:0] kind, logic [15:0] st, logic [15:0] en,
                              logic fixed, logic [2:0] fixed_st);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {en, st};
    do @(posedge clk); while (!s_axis_tready);
    if (fixed) begin
      // typed-in check of the status of this single-result request
      pending_answers.push_back(plain(fixed_st));
      predict_request(kind, st, en);
      void'(pending_answers.pop_back());
    end else predict_request(kind, st, en);
    s_axis_tvalid <= 1'b0;
    // table is busy for at least this cycle after taking an item
    @(posedge clk);
  endtask

  // directed table: extremes, every kind, every special case
  req_row_t directed [] = '{
    '{srt_pkg::KIND_LIST_ALL, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE}, // empty listing
    '{srt_pkg::KIND_LIST_FREE, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_SORT, 16'h0000, 16'h0000, 1'b1, srt_pkg::ST_DONE}, // sort on empty
    '{srt_pkg::KIND_BOOK, 16'h0001, 16'h0002, 1'b1, srt_pkg::ST_NO_SLOT},
    '{srt_pkg::KIND_CANCEL, 16'h0001, 16'h0002, 1'b1, srt_pkg::ST_NO_SLOT},
    '{srt_pkg::KIND_APPEND, 16'hFFFF, 16'hFFFF, 1'b1, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_APPEND, 16'h0000, 16'h0000, 1'b1, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_APPEND, 16'h5555, 16'hAAAA, 1'b1, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_APPEND, 16'h5555, 16'h1234, 1'b1, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_APPEND, 16'h5555, 16'hAAAA, 1'b1, srt_pkg::ST_DONE}, // duplicate slot
    '{srt_pkg::KIND_BOOK, 16'h5555, 16'hAAAA, 1'b1, srt_pkg::ST_DONE}, // first match only
    '{srt_pkg::KIND_BOOK, 16'h5555, 16'hAAAA, 1'b1, srt_pkg::ST_OCCUPIED},
    '{srt_pkg::KIND_BOOK, 16'hFFFF, 16'hFFFF, 1'b1, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_CANCEL, 16'h0000, 16'h0000, 1'b1, srt_pkg::ST_VACANT},
    '{srt_pkg::KIND_BOOK, 16'h5555, 16'h0000, 1'b1, srt_pkg::ST_NO_SLOT}, // start only
    '{srt_pkg::KIND_LIST_ALL, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_LIST_FREE, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE}, // skip booked
    '{srt_pkg::KIND_SORT, 16'h0000, 16'h0000, 1'b1, srt_pkg::ST_DONE}, // equal starts
    '{srt_pkg::KIND_LIST_ALL, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE},
    '{srt_pkg::KIND_CANCEL, 16'hFFFF, 16'hFFFF, 1'b1, srt_pkg::ST_DONE},
    '{KIND_BAD6, 16'hFFFF, 16'hFFFF, 1'b1, srt_pkg::ST_NO_SLOT}, // unused kinds
    '{KIND_BAD7, 16'h0000, 16'h0000, 1'b1, srt_pkg::ST_NO_SLOT},
    '{srt_pkg::KIND_LIST_FREE, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE}
  };

  function automatic logic [15:0] pick_time();
    // narrow range most of the time so book and cancel hit stored slots
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 7));
    return 16'($urandom);
  endfunction

  // stimulus
  initial begin
    int k;
    int r;
    logic [15:0] st, en;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send_request(directed[i].kind, directed[i].start_time, directed[i].end_time,
                   directed[i].fixed, directed[i].fixed_st);
      idle_gap();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      // hold off once until the table has answered everything
      if (i == N_RANDOM / 2) wait (pending_answers.size() == 0);
      r = $urandom_range(0, 99);
      st = pick_time();
      en = pick_time();
      if (tbl_count > 0 && $urandom_range(0, 1)) begin
        k = $urandom_range(0, tbl_count - 1);
        st = tbl_start[k];
        en = tbl_end[k];
      end
      if (r < 40) send_request(srt_pkg::KIND_APPEND, st, en, 1'b0, srt_pkg::ST_DONE);
      else if (r < 60) send_request(srt_pkg::KIND_BOOK, st, en, 1'b0, srt_pkg::ST_DONE);
      else if (r < 75) send_request(srt_pkg::KIND_CANCEL, st, en, 1'b0, srt_pkg::ST_DONE);
      else if (r < 82) send_request(srt_pkg::KIND_SORT, st, en, 1'b0, srt_pkg::ST_DONE);
      else if (r < 89) send_request(srt_pkg::KIND_LIST_ALL, st, en, 1'b0, srt_pkg::ST_DONE);
      else if (r < 96) send_request(srt_pkg::KIND_LIST_FREE, st, en, 1'b0, srt_pkg::ST_DONE);
      else send_request(3'($urandom_range(6, 7)), st, en, 1'b0, srt_pkg::ST_DONE);
      idle_gap();
    end
    // fill to the top to reach the table full answer
    while (tbl_count < MAX_SLOTS) begin
      send_request(srt_pkg::KIND_APPEND, 16'($urandom), 16'($urandom), 1'b0,
                   srt_pkg::ST_DONE);
    end
    send_request(srt_pkg::KIND_APPEND, 16'hFFFF, 16'h0000, 1'b1, srt_pkg::ST_FULL);
    send_request(srt_pkg::KIND_LIST_ALL, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE);
    send_request(srt_pkg::KIND_SORT, 16'h0000, 16'h0000, 1'b1, srt_pkg::ST_DONE);
    send_request(srt_pkg::KIND_LIST_FREE, 16'h0000, 16'h0000, 1'b0, srt_pkg::ST_DONE);
    stim_done = 1'b1;
  end

  // result side: random back pressure
  initial begin
    int r;
    @(negedge rst);
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 60) m_axis_tready <= 1'b1;
      else if (r < 95) m_axis_tready <= 1'b0;
      else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_answers.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          want = pending_answers.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser); fails++;
          end
          if (m_axis_tdata[15:0] !== want.slot_start) begin
            $error("slot_start: expected %0h, got %0h", want.slot_start,
                   m_axis_tdata[15:0]); fails++;
          end
          if (m_axis_tdata[31:16] !== want.slot_end) begin
            $error("slot_end: expected %0h, got %0h", want.slot_end,
                   m_axis_tdata[31:16]); fails++;
          end
          if (m_axis_tdata[32] !== want.slot_taken) begin
            $error("slot_taken: expected %0b, got %0b", want.slot_taken,
                   m_axis_tdata[32]); fails++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast); fails++;
          end
        end
      end
    end
  end

  // end of run
  initial begin
    @(negedge rst);
    fork
      begin
        wait (stim_done && pending_answers.size() == 0);
        repeat (200) @(posedge clk);
      end
      wait (idle_cycles >= WATCHDOG);
    join_any
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
    end else if (fails == 0 && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
